// File: rtl/spr_pkg.sv
package spr_pkg;

    // Fixed field widths of the request and result channels
    localparam int ACTION_W = 3;
    localparam int PAGE_W   = 31;
    localparam int SLOT_W   = 8;
    localparam int LEN_W    = 11;
    localparam int BIDX_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SPACE_W  = 12;

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FIRST  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_WRITE,
        OP_DELETE,
        OP_FIRST,
        OP_NEXT,
        OP_READ,
        OP_BAD
    } t_op;

    // Classified request, as queued between front and back
    typedef struct packed {
        t_op               op;
        logic              page_ok;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [BIDX_W-1:0] bidx;
        logic [BYTE_W-1:0] bval;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SLOT_Q,
        S_BYTE_Q,
        S_ADJ_RD,
        S_ADJ_WR,
        S_MV_RD,
        S_MV_WR,
        S_TRIM,
        S_DONE
    } t_state;

    // Back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic empty;
        logic has_free;
    } t_bk_stat;

endpackage

// File: rtl/spr_ifs.sv
interface spr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [30:0] page_number;
    logic [7:0]  slot_number;
    logic [10:0] record_length;
    logic [9:0]  byte_index;
    logic [7:0]  byte_value;

    modport source (
        output valid, action, page_number, slot_number, record_length,
               byte_index, byte_value,
        input  ready
    );
    modport sink (
        input  valid, action, page_number, slot_number, record_length,
               byte_index, byte_value,
        output ready
    );
endinterface

interface spr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         slot_number_res;
    logic [10:0]        record_length_res;
    logic [7:0]         read_byte;
    logic signed [11:0] free_space;
    logic               page_empty;

    modport source (
        output valid, status, slot_number_res, record_length_res, read_byte,
               free_space, page_empty,
        input  ready
    );
    modport sink (
        input  valid, status, slot_number_res, record_length_res, read_byte,
               free_space, page_empty,
        output ready
    );
endinterface

// File: rtl/spr_front.sv
module spr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spr_pkg::PAGE_W-1:0]    i_cfg_data,
    spr_in_if.sink                        i_in,
    output spr_pkg::t_cmd                 o_cmd,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready
);
    import spr_pkg::*;

    logic [PAGE_W-1:0] r_page_id;
    t_op               op;

    // Hold the page number register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_id <= '0;
        end else if (i_cfg_we) begin
            r_page_id <= i_cfg_data;
        end
    end

    // Decode the action code
    always_comb begin
        unique case (i_in.action)
            ACT_CLEAR:  op = OP_CLEAR;
            ACT_INSERT: op = OP_INSERT;
            ACT_WRITE:  op = OP_WRITE;
            ACT_DELETE: op = OP_DELETE;
            ACT_FIRST:  op = OP_FIRST;
            ACT_NEXT:   op = OP_NEXT;
            ACT_READ:   op = OP_READ;
            default:    op = OP_BAD;
        endcase
    end

    // Classify and hand the transfer to the queue
    assign o_cmd.op      = op;
    assign o_cmd.page_ok = (i_in.page_number == r_page_id);
    assign o_cmd.slot    = i_in.slot_number;
    assign o_cmd.len     = i_in.record_length;
    assign o_cmd.bidx    = i_in.byte_index;
    assign o_cmd.bval    = i_in.byte_value;
    assign o_cmd_valid   = i_in.valid;
    assign i_in.ready    = i_cmd_ready;

endmodule

// File: rtl/spr_queue.sv
module spr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spr_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    output logic          o_ready,
    output spr_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import spr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

endmodule

// File: rtl/spr_back.sv
module spr_back #(
    parameter int DATA_BYTES = 1024,
    parameter int SLOT_BYTES = 4,
    parameter int MAX_SLOTS  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spr_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    spr_out_if.source         o_out,
    output spr_pkg::t_bk_stat o_stat
);
    import spr_pkg::*;

    localparam int AW = $clog2(DATA_BYTES);
    localparam int PW = $clog2(DATA_BYTES + 1);
    localparam int FW = $clog2(DATA_BYTES + SLOT_BYTES + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = ((FW > LEN_W) ? FW : LEN_W) + 1;

    // Memories
    logic [BYTE_W-1:0] m_bytes [DATA_BYTES];
    logic [PW-1:0]     m_off   [MAX_SLOTS];
    logic [PW-1:0]     m_len   [MAX_SLOTS];
    logic [BYTE_W-1:0] r_bq;
    logic [PW-1:0]     r_offq;
    logic [PW-1:0]     r_lenq;

    // Control state
    t_state           r_state, n_state;
    logic [MAX_SLOTS-1:0] r_live, n_live;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_nlive, n_nlive;
    logic [PW-1:0]    r_used, n_used;
    logic [FW-1:0]    r_free, n_free;
    logic             r_ov, n_ov;

    // Working registers
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_i, n_i;
    logic [PW-1:0]    r_k, n_k;
    logic [PW-1:0]    r_doff, n_doff;
    logic [PW-1:0]    r_dlen, n_dlen;
    logic [SW-1:0]    r_sidx, n_sidx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_sres, n_sres;
    logic [LEN_W-1:0]    r_lres, n_lres;
    logic [BYTE_W-1:0]   r_bres, n_bres;

    // Memory ports
    logic              bw_en;
    logic [AW-1:0]     bw_addr;
    logic [BYTE_W-1:0] bw_data;
    logic [AW-1:0]     br_addr;
    logic              ow_en;
    logic              lw_en;
    logic [SW-1:0]     ow_addr;
    logic [PW-1:0]     ow_data;
    logic [PW-1:0]     lw_data;
    logic [SW-1:0]     sr_addr;

    logic              has_free;
    logic signed [EW-1:0] space;
    logic              slot_in_range;
    logic              live_t;
    logic [SW-1:0]     in_idx;
    logic [SW-1:0]     i_idx;
    logic [31:0]       pos32;
    logic [31:0]       dst32;
    logic              in_rec;

    // Space left for a new record
    assign has_free = (r_nlive < r_cnt);
    always_comb begin
        if (has_free) begin
            space = $signed(EW'(r_free));
        end else if (r_cnt >= CW'(MAX_SLOTS) || r_free < FW'(SLOT_BYTES)) begin
            space = '1;
        end else begin
            space = $signed(EW'(r_free - FW'(SLOT_BYTES)));
        end
    end

    assign in_idx        = SW'(i_cmd.slot);
    assign slot_in_range = (32'(i_cmd.slot) < 32'(r_cnt));
    assign live_t        = i_cmd.page_ok && slot_in_range && r_live[in_idx];
    assign i_idx         = r_i[SW-1:0];
    assign pos32         = 32'(r_offq) + 32'(r_cmd.bidx);
    assign in_rec        = (32'(r_cmd.bidx) < 32'(r_lenq));
    assign dst32         = 32'(r_k) - 32'd1 + 32'(r_dlen);

    assign o_cmd_ready = (r_state == S_IDLE) && !r_ov;

    // Sequence the actions
    always_comb begin
        n_state  = r_state;
        n_live   = r_live;
        n_cnt    = r_cnt;
        n_nlive  = r_nlive;
        n_used   = r_used;
        n_free   = r_free;
        n_ov     = r_ov;
        n_cmd    = r_cmd;
        n_i      = r_i;
        n_k      = r_k;
        n_doff   = r_doff;
        n_dlen   = r_dlen;
        n_sidx   = r_sidx;
        n_status = r_status;
        n_sres   = r_sres;
        n_lres   = r_lres;
        n_bres   = r_bres;
        bw_en    = 1'b0;
        bw_addr  = AW'(pos32);
        bw_data  = r_cmd.bval;
        br_addr  = AW'(pos32);
        ow_en    = 1'b0;
        lw_en    = 1'b0;
        ow_addr  = i_idx;
        ow_data  = r_offq + r_dlen;
        lw_data  = PW'(r_cmd.len);
        sr_addr  = in_idx;

        // Drop the result once transferred
        if (r_ov && o_out.ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_cmd    = i_cmd;
                    n_sidx   = in_idx;
                    n_status = ST_FAIL;
                    n_sres   = '0;
                    n_lres   = '0;
                    n_bres   = '0;
                    n_state  = S_DONE;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            n_live   = '0;
                            n_cnt    = '0;
                            n_nlive  = '0;
                            n_used   = PW'(DATA_BYTES);
                            n_free   = FW'(DATA_BYTES + SLOT_BYTES);
                            n_status = ST_OK;
                        end
                        OP_INSERT: begin
                            if (!has_free && r_cnt >= CW'(MAX_SLOTS)) begin
                                n_status = ST_FAIL;
                            end else if ($signed({{(EW-LEN_W){1'b0}}, i_cmd.len}) > space) begin
                                n_status = ST_DONE;
                            end else if (has_free) begin
                                n_i     = '0;
                                n_state = S_SCAN;
                            end else begin
                                // Append a new slot
                                ow_addr  = r_cnt[SW-1:0];
                                ow_data  = r_used - PW'(i_cmd.len);
                                lw_data  = PW'(i_cmd.len);
                                ow_en    = 1'b1;
                                lw_en    = 1'b1;
                                n_live[r_cnt[SW-1:0]] = 1'b1;
                                n_cnt    = r_cnt + CW'(1);
                                n_nlive  = r_nlive + CW'(1);
                                n_used   = r_used - PW'(i_cmd.len);
                                n_free   = r_free - FW'(i_cmd.len) - FW'(SLOT_BYTES);
                                n_sres   = SLOT_W'(r_cnt);
                                n_status = ST_OK;
                            end
                        end
                        OP_WRITE, OP_READ, OP_DELETE: begin
                            if (live_t) begin
                                sr_addr = in_idx;
                                n_state = S_SLOT_Q;
                            end
                        end
                        OP_FIRST: begin
                            n_i     = '0;
                            n_state = S_SCAN;
                        end
                        OP_NEXT: begin
                            if (i_cmd.page_ok && slot_in_range) begin
                                n_i     = CW'(i_cmd.slot) + CW'(1);
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_FAIL;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_cmd.op == OP_INSERT) begin
                    // Reuse the first free slot
                    if (!r_live[i_idx]) begin
                        ow_addr  = i_idx;
                        ow_data  = r_used - PW'(r_cmd.len);
                        ow_en    = 1'b1;
                        lw_en    = 1'b1;
                        n_live[i_idx] = 1'b1;
                        n_nlive  = r_nlive + CW'(1);
                        n_used   = r_used - PW'(r_cmd.len);
                        n_free   = r_free - FW'(r_cmd.len);
                        n_sres   = SLOT_W'(r_i);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end else if (r_i < r_cnt) begin
                    if (r_live[i_idx]) begin
                        n_sres   = SLOT_W'(r_i);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end else begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end
            end

            S_SLOT_Q: begin
                n_state = S_DONE;
                unique case (r_cmd.op)
                    OP_WRITE: begin
                        if (in_rec && pos32 < 32'(DATA_BYTES)) begin
                            bw_en    = 1'b1;
                            n_status = ST_OK;
                        end
                    end
                    OP_READ: begin
                        n_status = ST_OK;
                        n_lres   = LEN_W'(r_lenq);
                        if (in_rec && pos32 < 32'(DATA_BYTES)) begin
                            n_state = S_BYTE_Q;
                        end
                    end
                    OP_DELETE: begin
                        n_doff  = r_offq;
                        n_dlen  = r_lenq;
                        n_i     = '0;
                        n_state = S_ADJ_RD;
                    end
                    default: begin
                        n_status = ST_FAIL;
                    end
                endcase
            end

            S_BYTE_Q: begin
                n_bres  = r_bq;
                n_state = S_DONE;
            end

            S_ADJ_RD: begin
                if (r_i < r_cnt) begin
                    sr_addr = i_idx;
                    n_state = S_ADJ_WR;
                end else begin
                    n_k     = r_doff;
                    n_state = S_MV_RD;
                end
            end

            S_ADJ_WR: begin
                // Shift records that sat below the deleted one
                if (i_idx != r_sidx && r_live[i_idx] && r_offq < r_doff) begin
                    ow_addr = i_idx;
                    ow_data = r_offq + r_dlen;
                    ow_en   = 1'b1;
                end
                n_i     = r_i + CW'(1);
                n_state = S_ADJ_RD;
            end

            S_MV_RD: begin
                if (r_k > r_used) begin
                    br_addr = AW'(r_k - PW'(1));
                    n_state = S_MV_WR;
                end else begin
                    n_used  = r_used + r_dlen;
                    n_free  = r_free + FW'(r_dlen);
                    n_live[r_sidx] = 1'b0;
                    n_nlive = r_nlive - CW'(1);
                    n_state = S_TRIM;
                end
            end

            S_MV_WR: begin
                if (dst32 < 32'(DATA_BYTES)) begin
                    bw_addr = AW'(dst32);
                    bw_data = r_bq;
                    bw_en   = 1'b1;
                end
                n_k     = r_k - PW'(1);
                n_state = S_MV_RD;
            end

            S_TRIM: begin
                // Release trailing free slots one per cycle
                if (r_cnt != '0 && !r_live[SW'(r_cnt - CW'(1))]) begin
                    n_cnt  = r_cnt - CW'(1);
                    n_free = r_free + FW'(SLOT_BYTES);
                end else begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end

            S_DONE: begin
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_cnt   <= '0;
            r_nlive <= '0;
            r_used  <= PW'(DATA_BYTES);
            r_free  <= FW'(DATA_BYTES + SLOT_BYTES);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_cnt   <= n_cnt;
            r_nlive <= n_nlive;
            r_used  <= n_used;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_i      <= n_i;
        r_k      <= n_k;
        r_doff   <= n_doff;
        r_dlen   <= n_dlen;
        r_sidx   <= n_sidx;
        r_status <= n_status;
        r_sres   <= n_sres;
        r_lres   <= n_lres;
        r_bres   <= n_bres;
    end

    // Byte store
    always_ff @(posedge i_clk) begin
        if (bw_en) m_bytes[bw_addr] <= bw_data;
        r_bq <= m_bytes[br_addr];
    end

    // Slot directory
    always_ff @(posedge i_clk) begin
        if (ow_en) m_off[ow_addr] <= ow_data;
        if (lw_en) m_len[ow_addr] <= lw_data;
        r_offq <= m_off[sr_addr];
        r_lenq <= m_len[sr_addr];
    end

    // Drive the result channel
    assign o_out.valid             = r_ov;
    assign o_out.status            = r_status;
    assign o_out.slot_number_res   = r_sres;
    assign o_out.record_length_res = r_lres;
    assign o_out.read_byte         = r_bres;
    assign o_out.free_space        = SPACE_W'(space);
    assign o_out.page_empty        = (r_nlive == '0);

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.empty    = (r_nlive == '0);
    assign o_stat.has_free = has_free;

endmodule

// File: rtl/slotted_page_record_manager_core.sv
// Channel  | dir | handshake        | payload
// i_in     | in  | valid / ready    | action, page_number, slot_number, record_length,
//          |     |                  | byte_index, byte_value
// o_out    | out | valid / ready    | status, slot_number_res, record_length_res,
//          |     |                  | read_byte, free_space, page_empty
// i_cfg    | in  | i_cfg_we         | i_cfg_data (page number)
//
// One request runs at a time in the back sequencer; a two-entry queue lets the front take
// requests while the back is busy or a result waits, which holds the back end.
// Clear, appending insert and refused requests go straight to the result; first, next and
// reusing insert scan the slots; byte write and read query the slot directory, a read also
// the byte store; delete adjusts slot offsets, moves the bytes and releases trailing slots.
// Reset is synchronous; the byte store and slot directory memories are not cleared.
module slotted_page_record_manager_core #(
    parameter int DATA_BYTES = 1024,
    parameter int SLOT_BYTES = 4,
    parameter int MAX_SLOTS  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spr_pkg::PAGE_W-1:0] i_cfg_data,
    spr_in_if.sink                     i_in,
    spr_out_if.source                  o_out
);
    import spr_pkg::*;

    t_cmd     f_cmd;
    logic     f_valid;
    logic     f_ready;
    t_cmd     q_cmd;
    logic     q_valid;
    logic     q_ready;
    t_bk_stat bk_stat;

    // Accept and classify requests
    spr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready)
    );

    // Decouple front and back
    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    // Execute on the page
    spr_back #(
        .DATA_BYTES (DATA_BYTES),
        .SLOT_BYTES (SLOT_BYTES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .o_out       (o_out),
        .o_stat      (bk_stat)
    );

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.page_empty == bk_stat.empty))
        else $error("page_empty differs from live slot state");

    a_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.free_space == 12'hFFF) |-> !bk_stat.has_free)
        else $error("no space reported while a free slot exists");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |-> bk_stat.idle)
        else $error("request taken while back end busy");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |=> !bk_stat.idle)
        else $error("back end did not start on a taken request");

endmodule
